// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the running statistics RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define PMRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmrs: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PMRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmrs: next-cycle check failed");

`else

`define PMRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PMRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrs_pkg
// Widths, codes, types and step counts of the running statistics block.
// ----------------------------------------------------------------------------
package pmrs_pkg;

    localparam int NUM_METRICS = 16;
    localparam int IDX_W       = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;

    localparam int CMD_W  = 2;
    localparam int MIDX_W = 8;
    localparam int VAL_W  = 24;
    localparam int STD_W  = 23;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 40;
    localparam int SQ_W   = 48;   // square of one sample
    localparam int SQS_W  = 64;
    localparam int NUM_W  = 80;   // count * sumsq - sum^2
    localparam int DEN_W  = 32;   // count * (count - 1)
    localparam int ROOT_W = 32;
    localparam int REM_W  = 34;

    localparam int MEAN_CNT_W = $clog2(SUM_W);
    localparam int STD_CNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    // unused code, behaves as a read
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SAT   = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [STD_W-1:0] STD_MAX   = '1;

    localparam logic [STD_CNT_W-1:0] MULN_LAST = STD_CNT_W'(CNT_W - 1);
    localparam logic [STD_CNT_W-1:0] MULS_LAST = STD_CNT_W'(SUM_W - 1);
    localparam logic [STD_CNT_W-1:0] DIV_LAST  = STD_CNT_W'(SQS_W - 1);
    localparam logic [STD_CNT_W-1:0] SQRT_LAST = STD_CNT_W'(ROOT_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL_N,
        PH_MUL_S,
        PH_CHECK,
        PH_DIV,
        PH_SQRT
    } t_std_phase;

    typedef struct packed {
        logic clear;
        logic update;
    } t_store_ctrl;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] first_val;
        logic signed [VAL_W-1:0] last_val;
        logic signed [VAL_W-1:0] min_val;
        logic signed [VAL_W-1:0] max_val;
        logic signed [SUM_W-1:0] sum;
        logic [SQS_W-1:0]        sumsq;
    } t_stats;

endpackage

// ===== rtl/pmrs_in_if.sv =====
// ----------------------------------------------------------------------------
// pmrs_in_if
// Command channel: one transaction per command.
// ----------------------------------------------------------------------------
interface pmrs_in_if;
    logic                                valid;
    logic                                ready;
    logic [pmrs_pkg::CMD_W-1:0]          command;
    logic [pmrs_pkg::MIDX_W-1:0]         metric_index;
    logic signed [pmrs_pkg::VAL_W-1:0]   sample_value;
    logic                                sample_present;

    modport source (
        output valid, command, metric_index, sample_value, sample_present,
        input  ready
    );
    modport sink (
        input  valid, command, metric_index, sample_value, sample_present,
        output ready
    );
endinterface

// ===== rtl/pmrs_out_if.sv =====
// ----------------------------------------------------------------------------
// pmrs_out_if
// Result channel: one transaction per command.
// ----------------------------------------------------------------------------
interface pmrs_out_if;
    logic                              valid;
    logic                              ready;
    logic [pmrs_pkg::STAT_W-1:0]       status;
    logic [pmrs_pkg::CNT_W-1:0]        sample_count;
    logic signed [pmrs_pkg::VAL_W-1:0] first_value;
    logic signed [pmrs_pkg::VAL_W-1:0] last_value;
    logic signed [pmrs_pkg::VAL_W-1:0] min_value;
    logic signed [pmrs_pkg::VAL_W-1:0] max_value;
    logic signed [pmrs_pkg::VAL_W-1:0] mean_value;
    logic [pmrs_pkg::STD_W-1:0]        std_value;
    logic                              stats_valid;
    logic                              std_valid;

    modport source (
        output valid, status, sample_count, first_value, last_value, min_value,
               max_value, mean_value, std_value, stats_valid, std_valid,
        input  ready
    );
    modport sink (
        input  valid, status, sample_count, first_value, last_value, min_value,
               max_value, mean_value, std_value, stats_valid, std_valid,
        output ready
    );
endinterface

// ===== rtl/pmrs_store.sv =====
// ----------------------------------------------------------------------------
// pmrs_store
// Per-metric statistics registers with sample update and clear-all.
// ----------------------------------------------------------------------------
module pmrs_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pmrs_pkg::t_store_ctrl              i_ctrl,
    input  logic [pmrs_pkg::IDX_W-1:0]         i_idx,
    input  logic signed [pmrs_pkg::VAL_W-1:0]  i_sample,
    input  logic [pmrs_pkg::SQ_W-1:0]          i_square,
    output pmrs_pkg::t_stats                   o_stats
);
    import pmrs_pkg::*;

    logic [CNT_W-1:0]        r_count [NUM_METRICS];
    logic signed [SUM_W-1:0] r_sum   [NUM_METRICS];
    logic [SQS_W-1:0]        r_sumsq [NUM_METRICS];
    logic signed [VAL_W-1:0] r_first [NUM_METRICS];
    logic signed [VAL_W-1:0] r_last  [NUM_METRICS];
    logic signed [VAL_W-1:0] r_min   [NUM_METRICS];
    logic signed [VAL_W-1:0] r_max   [NUM_METRICS];

    logic w_empty;

    assign w_empty = (r_count[i_idx] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int m = 0; m < NUM_METRICS; m++) begin
                r_count[m] <= '0;
                r_sum[m]   <= '0;
                r_sumsq[m] <= '0;
            end
        end else if (i_ctrl.update) begin
            r_count[i_idx] <= r_count[i_idx] + 1'b1;
            r_sum[i_idx]   <= r_sum[i_idx] + SUM_W'(i_sample);
            r_sumsq[i_idx] <= r_sumsq[i_idx] + SQS_W'(i_square);
        end
    end

    // first/min/max restart on the first sample after a clear
    always_ff @(posedge i_clk) begin
        if (i_ctrl.update) begin
            r_last[i_idx] <= i_sample;
            if (w_empty) begin
                r_first[i_idx] <= i_sample;
            end
            if (w_empty || i_sample < r_min[i_idx]) begin
                r_min[i_idx] <= i_sample;
            end
            if (w_empty || i_sample > r_max[i_idx]) begin
                r_max[i_idx] <= i_sample;
            end
        end
    end

    always_comb begin
        o_stats.count     = r_count[i_idx];
        o_stats.first_val = r_first[i_idx];
        o_stats.last_val  = r_last[i_idx];
        o_stats.min_val   = r_min[i_idx];
        o_stats.max_val   = r_max[i_idx];
        o_stats.sum       = r_sum[i_idx];
        o_stats.sumsq     = r_sumsq[i_idx];
    end

endmodule

// ===== rtl/pmrs_mean_div.sv =====
// ----------------------------------------------------------------------------
// pmrs_mean_div
// Bit-serial restoring divider: sum / count, truncated toward zero.
// ----------------------------------------------------------------------------
module pmrs_mean_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [pmrs_pkg::SUM_W-1:0]  i_sum,
    input  logic [pmrs_pkg::CNT_W-1:0]         i_count,
    output logic                               o_busy,
    output logic signed [pmrs_pkg::VAL_W-1:0]  o_mean
);
    import pmrs_pkg::*;

    logic                  r_busy;
    logic [MEAN_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]      r_q;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_div;
    logic                  r_neg;

    logic [CNT_W:0]   w_trial;
    logic             w_ge;
    logic [SUM_W-1:0] w_mag;

    assign w_mag   = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == MEAN_CNT_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift one quotient bit in per cycle, dividend bits out at the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_div <= i_count;
            r_neg <= i_sum[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? CNT_W'(w_trial - {1'b0, r_div}) : CNT_W'(w_trial);
            r_q   <= {r_q[SUM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_mean = r_neg ? VAL_W'(-r_q[VAL_W-1:0]) : r_q[VAL_W-1:0];

endmodule

// ===== rtl/pmrs_std_unit.sv =====
// ----------------------------------------------------------------------------
// pmrs_std_unit
// Bit-serial deviation: shift-add numerator, restoring divide, digit sqrt.
// ----------------------------------------------------------------------------
module pmrs_std_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pmrs_pkg::CNT_W-1:0]         i_count,
    input  logic signed [pmrs_pkg::SUM_W-1:0]  i_sum,
    input  logic [pmrs_pkg::SQS_W-1:0]         i_sumsq,
    output logic                               o_busy,
    output logic [pmrs_pkg::STD_W-1:0]         o_std
);
    import pmrs_pkg::*;

    t_std_phase            r_phase, n_phase;
    logic [STD_CNT_W-1:0]  r_cnt, n_cnt;

    logic [NUM_W-1:0]  r_acc;
    logic [NUM_W-1:0]  r_mcand;
    logic [SUM_W-1:0]  r_mplier;
    logic [SUM_W-1:0]  r_mag;
    logic [DEN_W-1:0]  r_den;
    logic [REM_W-1:0]  r_rem;
    logic [SQS_W-1:0]  r_x;
    logic [ROOT_W-1:0] r_root;
    logic              r_sat;

    logic [SUM_W-1:0]  w_mag;
    logic [DEN_W:0]    w_dtrial;
    logic              w_dge;
    logic [REM_W-1:0]  w_stry;
    logic [REM_W-1:0]  w_sref;
    logic              w_sge;
    logic              w_last;

    assign w_mag    = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign w_dtrial = {r_rem[DEN_W-1:0], r_x[SQS_W-1]};
    assign w_dge    = (w_dtrial >= {1'b0, r_den});
    assign w_stry   = {r_rem[ROOT_W-1:0], r_x[SQS_W-1:SQS_W-2]};
    assign w_sref   = {r_root, 2'b01};
    assign w_sge    = (w_stry >= w_sref);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt + 1'b1;
        w_last  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_phase = PH_MUL_N;
                end
            end
            PH_MUL_N: begin
                w_last = (r_cnt == MULN_LAST);
                if (w_last) begin
                    n_phase = PH_MUL_S;
                    n_cnt   = '0;
                end
            end
            PH_MUL_S: begin
                w_last = (r_cnt == MULS_LAST);
                if (w_last) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_DIV;
                n_cnt   = '0;
            end
            PH_DIV: begin
                w_last = (r_cnt == DIV_LAST);
                if (w_last) begin
                    n_phase = PH_SQRT;
                    n_cnt   = '0;
                end
            end
            PH_SQRT: begin
                w_last = (r_cnt == SQRT_LAST);
                if (w_last) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_den    <= DEN_W'(i_count * (i_count - 1'b1));
                    r_acc    <= '0;
                    r_mcand  <= NUM_W'(i_sumsq);
                    r_mplier <= SUM_W'(i_count);
                    r_mag    <= w_mag;
                end
            end
            PH_MUL_N: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                if (w_last) begin
                    r_mcand  <= NUM_W'(r_mag);
                    r_mplier <= r_mag;
                end else begin
                    r_mcand  <= {r_mcand[NUM_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[SUM_W-1:1]};
                end
            end
            PH_MUL_S: begin
                // subtract sum^2 one partial product at a time
                if (r_mplier[0]) begin
                    r_acc <= r_acc - r_mcand;
                end
                r_mcand  <= {r_mcand[NUM_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[SUM_W-1:1]};
            end
            PH_CHECK: begin
                // quotient needs more than 64 bits when the top part reaches the divisor
                r_sat <= ({16'b0, r_acc[NUM_W-1:SQS_W]} >= r_den);
                r_rem <= REM_W'(r_acc[NUM_W-1:SQS_W]);
                r_x   <= r_acc[SQS_W-1:0];
            end
            PH_DIV: begin
                r_x <= {r_x[SQS_W-2:0], w_dge};
                if (w_last) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem <= w_dge ? REM_W'(w_dtrial - {1'b0, r_den}) : REM_W'(w_dtrial);
                end
            end
            PH_SQRT: begin
                r_rem  <= w_sge ? (w_stry - w_sref) : w_stry;
                r_root <= {r_root[ROOT_W-2:0], w_sge};
                r_x    <= {r_x[SQS_W-3:0], 2'b00};
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_busy = (r_phase != PH_IDLE);
    assign o_std  = (r_sat || r_root > ROOT_W'(STD_MAX)) ? STD_MAX : r_root[STD_W-1:0];

endmodule

// ===== rtl/per_metric_running_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// per_metric_running_statistics_unit
// Running count, first, last, min, max, mean and deviation per metric.
//
// i_item carries one command per transaction: add a sample, read a metric
// or clear all metrics. o_result returns exactly one transaction for each
// command with the addressed metric's statistics after the command.
// Between acceptance and result, the deviation path runs a 16-step and a
// 40-step shift-add multiply, a 64-step restoring divide and a 32-step
// square root, one bit or one digit per cycle; the mean divider runs
// alongside it. A command with an out-of-range index skips both units.
// One command is in flight at a time; i_item.ready is high only while
// the block is idle.
// The result sits in an output register, so the next command is taken
// while a finished result waits; a stalled receiver holds the block only
// when the next result is ready to go out.
// Reset zeroes all counts and sums; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_metric_running_statistics_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmrs_in_if.sink     i_item,
    pmrs_out_if.source  o_result
);
    import pmrs_pkg::*;

    t_top_state r_state, n_state;

    logic [CMD_W-1:0]        r_cmd;
    logic [MIDX_W-1:0]       r_idx;
    logic signed [VAL_W-1:0] r_sample;
    logic                    r_present;
    logic                    r_in_range;
    logic [SQ_W-1:0]         r_square;
    logic [STAT_W-1:0]       r_status;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic [CNT_W-1:0]        r_out_count;
    logic signed [VAL_W-1:0] r_out_first;
    logic signed [VAL_W-1:0] r_out_last;
    logic signed [VAL_W-1:0] r_out_min;
    logic signed [VAL_W-1:0] r_out_max;
    logic signed [VAL_W-1:0] r_out_mean;
    logic [STD_W-1:0]        r_out_std;
    logic                    r_out_stats_ok;
    logic                    r_out_std_ok;

    logic                    w_accept;
    logic                    w_emit;
    logic                    w_start;
    logic                    w_add;
    t_store_ctrl             w_ctrl;
    t_stats                  w_stats;
    logic                    w_mean_busy;
    logic                    w_std_busy;
    logic signed [VAL_W-1:0] w_mean;
    logic [STD_W-1:0]        w_std;
    logic                    w_has1;
    logic                    w_has2;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_add    = r_in_range && (r_cmd == CMD_ADD) && r_present;
    assign w_has1   = r_in_range && (w_stats.count != '0);
    assign w_has2   = r_in_range && (w_stats.count > CNT_W'(1));

    pmrs_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_idx    (r_idx[IDX_W-1:0]),
        .i_sample (r_sample),
        .i_square (r_square),
        .o_stats  (w_stats)
    );

    pmrs_mean_div u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sum   (w_stats.sum),
        .i_count (w_stats.count),
        .o_busy  (w_mean_busy),
        .o_mean  (w_mean)
    );

    pmrs_std_unit u_std (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_count (w_stats.count),
        .i_sum   (w_stats.sum),
        .i_sumsq (w_stats.sumsq),
        .o_busy  (w_std_busy),
        .o_std   (w_std)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        i_item.ready = 1'b0;
        w_ctrl       = '0;
        w_start      = 1'b0;
        w_emit       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                w_ctrl.clear  = (r_cmd == CMD_CLEAR);
                w_ctrl.update = w_add && (w_stats.count != COUNT_MAX);
                n_state       = r_in_range ? ST_LOAD : ST_DONE;
            end
            ST_LOAD: begin
                w_start = 1'b1;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (!w_mean_busy && !w_std_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= i_item.command;
            r_idx      <= i_item.metric_index;
            r_sample   <= i_item.sample_value;
            r_present  <= i_item.sample_present;
            r_in_range <= ({1'b0, i_item.metric_index} < (MIDX_W + 1)'(NUM_METRICS));
        end
        if (r_state == ST_SQUARE) begin
            r_square <= SQ_W'(r_sample * r_sample);
        end
        if (r_state == ST_UPDATE) begin
            priority if (!r_in_range) begin
                r_status <= STATUS_RANGE;
            end else if (w_add && w_stats.count == COUNT_MAX) begin
                r_status <= STATUS_SAT;
            end else begin
                r_status <= STATUS_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // zero every field that has no meaning for this count
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status   <= r_status;
            r_out_count    <= r_in_range ? w_stats.count : '0;
            r_out_first    <= w_has1 ? w_stats.first_val : '0;
            r_out_last     <= w_has1 ? w_stats.last_val : '0;
            r_out_min      <= w_has1 ? w_stats.min_val : '0;
            r_out_max      <= w_has1 ? w_stats.max_val : '0;
            r_out_mean     <= w_has1 ? w_mean : '0;
            r_out_std      <= w_has2 ? w_std : '0;
            r_out_stats_ok <= w_has1;
            r_out_std_ok   <= w_has2;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.sample_count = r_out_count;
    assign o_result.first_value  = r_out_first;
    assign o_result.last_value   = r_out_last;
    assign o_result.min_value    = r_out_min;
    assign o_result.max_value    = r_out_max;
    assign o_result.mean_value   = r_out_mean;
    assign o_result.std_value    = r_out_std;
    assign o_result.stats_valid  = r_out_stats_ok;
    assign o_result.std_valid    = r_out_std_ok;

    `PMRS_ASSERT_IMPLY(a_std_needs_stats, i_clk, i_rst_n, o_result.valid && o_result.std_valid, o_result.stats_valid)
    `PMRS_ASSERT_IMPLY(a_range_empty, i_clk, i_rst_n, o_result.valid && o_result.status == STATUS_RANGE, o_result.sample_count == '0 && !o_result.stats_valid)
    `PMRS_ASSERT_IMPLY(a_units_idle, i_clk, i_rst_n, r_state == ST_IDLE, !w_mean_busy && !w_std_busy)
    `PMRS_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, w_emit, r_out_valid && r_state == ST_IDLE)

endmodule

// ===== tb/tb_per_metric_running_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// tb_per_metric_running_statistics_unit
// Drives add, read and clear commands into the running statistics block
// and checks every result transaction field by field against a behavioral
// predictor of per-metric count, first, last, min, max, mean and deviation.
// ----------------------------------------------------------------------------
module tb_per_metric_running_statistics_unit;
    import pmrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_STALL     = 2000;
    localparam int RANDOM_ITEMS   = 1600;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [MIDX_W-1:0]       idx;
        logic signed [VAL_W-1:0] val;
        logic                    present;
    } t_cmd_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] first_val;
        logic signed [VAL_W-1:0] last_val;
        logic signed [VAL_W-1:0] min_val;
        logic signed [VAL_W-1:0] max_val;
        logic signed [VAL_W-1:0] mean_val;
        logic [STD_W-1:0]        std_val;
        logic                    stats_ok;
        logic                    std_ok;
    } t_stats_result;

    // How a directed row gets its expected result.
    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_EMPTY,
        EXP_RANGE,
        EXP_SINGLE
    } t_exp_kind;

    typedef struct {
        t_cmd_item item;
        t_exp_kind kind;
    } t_stim_row;

    logic clk;
    logic rst_n;

    pmrs_in_if  item_if ();
    pmrs_out_if res_if ();

    per_metric_running_statistics_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (res_if)
    );

    // Predictor state, one entry per metric.
    logic [CNT_W-1:0]        cnt_q    [NUM_METRICS];
    logic signed [VAL_W-1:0] first_q  [NUM_METRICS];
    logic signed [VAL_W-1:0] last_q   [NUM_METRICS];
    logic signed [VAL_W-1:0] min_q    [NUM_METRICS];
    logic signed [VAL_W-1:0] max_q    [NUM_METRICS];
    longint                  sum_q    [NUM_METRICS];
    longint unsigned         sqsum_q  [NUM_METRICS];

    t_stats_result expected_results[$];
    t_stim_row     directed_rows[$];

    bit failed;
    bit sender_done;
    bit hold_off_req;
    int accepted_results;
    int idle_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [STD_W-1:0] deviation_of(int m);
        logic [127:0]    num;
        logic [127:0]    den;
        logic [127:0]    quo;
        longint unsigned mag;
        longint unsigned root;
        mag  = (sum_q[m] < 0) ? longint'(-sum_q[m]) : sum_q[m];
        num  = 128'(cnt_q[m]) * 128'(sqsum_q[m]) - 128'(mag) * 128'(mag);
        den  = 128'(cnt_q[m]) * 128'(cnt_q[m] - 1);
        quo  = num / den;
        if (quo[127:64] != 0) return STD_MAX;
        root = int_sqrt(quo[63:0]);
        return (root > longint'(STD_MAX)) ? STD_MAX : STD_W'(root);
    endfunction

    // Apply one command to the metric stores and return the statistics it reports.
    function automatic t_stats_result apply_command(t_cmd_item it);
        t_stats_result r;
        int            m;
        longint        s;
        r = '0;
        m = it.idx;
        s = it.val;
        if (it.cmd == CMD_CLEAR) begin
            for (int k = 0; k < NUM_METRICS; k++) begin
                cnt_q[k]   = '0;
                sum_q[k]   = 0;
                sqsum_q[k] = 0;
            end
        end
        if (m >= NUM_METRICS) begin
            r.status = STATUS_RANGE;
            return r;
        end
        if (it.cmd == CMD_ADD && it.present) begin
            if (cnt_q[m] == COUNT_MAX) begin
                r.status = STATUS_SAT;
            end else begin
                cnt_q[m]++;
                if (cnt_q[m] == 1) begin
                    first_q[m] = it.val;
                    min_q[m]   = it.val;
                    max_q[m]   = it.val;
                end
                last_q[m] = it.val;
                if (it.val < min_q[m]) min_q[m] = it.val;
                if (it.val > max_q[m]) max_q[m] = it.val;
                sum_q[m]   += s;
                sqsum_q[m] += longint'(s * s);
            end
        end
        r.count = cnt_q[m];
        if (cnt_q[m] >= 1) begin
            r.first_val = first_q[m];
            r.last_val  = last_q[m];
            r.min_val   = min_q[m];
            r.max_val   = max_q[m];
            r.mean_val  = VAL_W'(sum_q[m] / longint'(cnt_q[m]));
            r.stats_ok  = 1'b1;
        end
        if (cnt_q[m] >= 2) begin
            r.std_val = deviation_of(m);
            r.std_ok  = 1'b1;
        end
        return r;
    endfunction

    function automatic t_stim_row row(logic [CMD_W-1:0] c, int i, int v, bit p, t_exp_kind k);
        t_stim_row s;
        s.item.cmd     = c;
        s.item.idx     = MIDX_W'(i);
        s.item.val     = VAL_W'(v);
        s.item.present = p;
        s.kind         = k;
        return s;
    endfunction

    function automatic t_cmd_item random_item();
        t_cmd_item it;
        int        sel;
        sel        = $urandom_range(0, 99);
        it.cmd     = CMD_ADD;
        it.idx     = MIDX_W'($urandom_range(0, 3));
        it.val     = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom)
                                                 : VAL_W'($urandom_range(0, 4095)) - 2048;
        it.present = 1'b1;
        if (sel < 50) begin
            // dense adds on a few metrics
        end else if (sel < 62) begin
            it.idx = MIDX_W'($urandom_range(0, NUM_METRICS - 1));
        end else if (sel < 82) begin
            it.cmd = CMD_READ;
            it.idx = MIDX_W'($urandom_range(0, NUM_METRICS - 1));
            it.present = 1'($urandom);
        end else if (sel < 88) begin
            it.cmd = CMD_W'($urandom);
            if (it.cmd == CMD_CLEAR) it.cmd = CMD_READ;
            it.idx = MIDX_W'($urandom_range(NUM_METRICS, 255));
            it.present = 1'($urandom);
        end else if (sel < 93) begin
            it.present = 1'b0;
        end else if (sel < 97) begin
            it.cmd = CMD_SPARE;
            it.present = 1'($urandom);
        end else if (sel < 98) begin
            it.cmd = CMD_CLEAR;
            it.idx = MIDX_W'($urandom);
        end else begin
            it.idx = MIDX_W'($urandom_range(0, NUM_METRICS - 1));
            it.val = ($urandom_range(0, 1) == 0) ? 24'sh7FFFFF : 24'sh800000;
        end
        return it;
    endfunction

    // Hold valid across back-to-back transactions; drop it only before a gap.
    task automatic send_item(t_cmd_item it, int gap, t_exp_kind kind);
        t_stats_result pred;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid          <= 1'b1;
        item_if.command        <= it.cmd;
        item_if.metric_index   <= it.idx;
        item_if.sample_value   <= it.val;
        item_if.sample_present <= it.present;
        do @(posedge clk); while (!item_if.ready);
        pred = apply_command(it);
        case (kind)
            EXP_EMPTY: pred = '0;
            EXP_RANGE: begin
                pred = '0;
                pred.status = STATUS_RANGE;
            end
            EXP_SINGLE: begin
                pred = '0;
                pred.count     = 1;
                pred.first_val = it.val;
                pred.last_val  = it.val;
                pred.min_val   = it.val;
                pred.max_val   = it.val;
                pred.mean_val  = it.val;
                pred.stats_ok  = 1'b1;
            end
            default: ;
        endcase
        expected_results.push_back(pred);
    endtask

    function automatic int draw_gap(int n);
        return ((n / 100) % 4 == 1) ? 0 : $urandom_range(0, 15);
    endfunction

    // Stimulus
    initial begin
        t_cmd_item it;
        int        n;
        rst_n                  <= 1'b0;
        item_if.valid          <= 1'b0;
        item_if.command        <= CMD_READ;
        item_if.metric_index   <= '0;
        item_if.sample_value   <= '0;
        item_if.sample_present <= 1'b0;
        sender_done  = 0;
        hold_off_req = 0;
        for (int k = 0; k < NUM_METRICS; k++) begin
            cnt_q[k] = '0; first_q[k] = '0; last_q[k] = '0;
            min_q[k] = '0; max_q[k] = '0; sum_q[k] = 0; sqsum_q[k] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        directed_rows.push_back(row(CMD_READ,  0,   0,        1, EXP_EMPTY));
        directed_rows.push_back(row(CMD_ADD,   16,  5,        1, EXP_RANGE));
        directed_rows.push_back(row(CMD_ADD,   255, -1,       1, EXP_RANGE));
        directed_rows.push_back(row(CMD_READ,  200, 0,        0, EXP_RANGE));
        directed_rows.push_back(row(CMD_ADD,   1,   8388607,  1, EXP_SINGLE));
        directed_rows.push_back(row(CMD_ADD,   1,   -8388608, 1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   1,   0,        1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_READ,  1,   0,        1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   2,   1234,     0, EXP_EMPTY));
        directed_rows.push_back(row(CMD_SPARE, 1,   77,       1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   3,   -8388608, 1, EXP_SINGLE));
        directed_rows.push_back(row(CMD_ADD,   3,   -8388608, 1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   15,  -3,       1, EXP_SINGLE));
        directed_rows.push_back(row(CMD_ADD,   15,  4,        1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   15,  -7,       1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_CLEAR, 17,  0,        1, EXP_RANGE));
        directed_rows.push_back(row(CMD_READ,  1,   0,        0, EXP_EMPTY));
        directed_rows.push_back(row(CMD_ADD,   4,   1,        1, EXP_SINGLE));
        directed_rows.push_back(row(CMD_ADD,   4,   2,        1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   5,   8388607,  1, EXP_SINGLE));
        directed_rows.push_back(row(CMD_ADD,   5,   -8388608, 1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_ADD,   5,   8388607,  1, EXP_PREDICT));
        directed_rows.push_back(row(CMD_CLEAR, 5,   0,        0, EXP_EMPTY));
        foreach (directed_rows[r])
            send_item(directed_rows[r].item, draw_gap(0), directed_rows[r].kind);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_off_req = 1;
            if (n == 800) begin
                // drain before continuing
                item_if.valid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge clk);
            end
            it = random_item();
            send_item(it, draw_gap(n), EXP_PREDICT);
        end
        item_if.valid <= 1'b0;
        sender_done = 1;
    end

    // Result receiver and checker
    initial begin
        t_stats_result exp_r;
        t_stats_result act;
        int            gap;
        res_if.ready     <= 1'b0;
        accepted_results  = 0;
        failed            = 0;
        @(posedge rst_n);
        forever begin
            gap = draw_gap(accepted_results);
            if (hold_off_req) begin
                hold_off_req = 0;
                gap = LONG_STALL;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            accepted_results++;
            act.status    = res_if.status;
            act.count     = res_if.sample_count;
            act.first_val = res_if.first_value;
            act.last_val  = res_if.last_value;
            act.min_val   = res_if.min_value;
            act.max_val   = res_if.max_value;
            act.mean_val  = res_if.mean_value;
            act.std_val   = res_if.std_value;
            act.stats_ok  = res_if.stats_valid;
            act.std_ok    = res_if.std_valid;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction, status %0d", act.status);
                failed = 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (act.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, act.status);
                    failed = 1;
                end
                if (act.count !== exp_r.count) begin
                    $error("sample_count: expected %0d, got %0d", exp_r.count, act.count);
                    failed = 1;
                end
                if (act.first_val !== exp_r.first_val) begin
                    $error("first_value: expected %0d, got %0d",
                           exp_r.first_val, act.first_val);
                    failed = 1;
                end
                if (act.last_val !== exp_r.last_val) begin
                    $error("last_value: expected %0d, got %0d", exp_r.last_val, act.last_val);
                    failed = 1;
                end
                if (act.min_val !== exp_r.min_val) begin
                    $error("min_value: expected %0d, got %0d", exp_r.min_val, act.min_val);
                    failed = 1;
                end
                if (act.max_val !== exp_r.max_val) begin
                    $error("max_value: expected %0d, got %0d", exp_r.max_val, act.max_val);
                    failed = 1;
                end
                if (act.mean_val !== exp_r.mean_val) begin
                    $error("mean_value: expected %0d, got %0d", exp_r.mean_val, act.mean_val);
                    failed = 1;
                end
                if (act.std_val !== exp_r.std_val) begin
                    $error("std_value: expected %0d, got %0d", exp_r.std_val, act.std_val);
                    failed = 1;
                end
                if (act.stats_ok !== exp_r.stats_ok) begin
                    $error("stats_valid: expected %0d, got %0d",
                           exp_r.stats_ok, act.stats_ok);
                    failed = 1;
                end
                if (act.std_ok !== exp_r.std_ok) begin
                    $error("std_valid: expected %0d, got %0d", exp_r.std_ok, act.std_ok);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // End of run
    initial begin
        wait (sender_done);
        wait (expected_results.size() == 0);
        repeat (400) @(posedge clk);
        if (!failed && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d results never arrived", expected_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pmrs_pkg.sv
rtl/pmrs_in_if.sv
rtl/pmrs_out_if.sv
rtl/pmrs_store.sv
rtl/pmrs_mean_div.sv
rtl/pmrs_std_unit.sv
rtl/per_metric_running_statistics_unit.sv
tb/tb_per_metric_running_statistics_unit.sv
